// File: design/pds_pkg.sv
// Shared types, constants and helper functions of the percent decoder.
package pds_pkg;

  localparam logic [7:0]  ChPercent         = 8'h25;
  localparam int unsigned Nibble            = 4;
  localparam int unsigned MaxOut            = 3;
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [1:0]              cnt;
    logic [MaxOut-1:0][7:0]  data;
    logic                    last;
  } pds_rec_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } pds_hex_t;

  function automatic pds_hex_t hex_decode(logic [7:0] c);
    pds_hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.valid = 1'b1;
      h.value = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] v, logic lower);
    logic [7:0] base;
    base = lower ? 8'h61 : 8'h41;
    if (v < 4'd10) begin
      return {4'h3, v};
    end
    return base + {4'h0, v} - 8'd10;
  endfunction

  function automatic pds_rec_t rec_add(pds_rec_t r, logic [7:0] b);
    pds_rec_t o;
    o = r;
    case (r.cnt)
      2'd0:    o.data[0] = b;
      2'd1:    o.data[1] = b;
      default: o.data[2] = b;
    endcase
    if (r.cnt != 2'd3) begin
      o.cnt = r.cnt + 2'd1;
    end
    return o;
  endfunction

endpackage

// File: design/pds_front.sv
// Front end: accepts raw bytes, tracks pending escapes and builds output records.
module pds_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pds_pkg::pds_rec_t q_rec_o
);
  import pds_pkg::*;

  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [3:0] pend_digit_q, pend_digit_d;
  logic       pend_case_q, pend_case_d;
  logic       accept;
  pds_hex_t   hx;
  pds_rec_t   rec;

  assign accept = push_i & ~q_full_i;

  always_comb begin
    hx           = hex_decode(in_byte_i);
    rec          = '0;
    pend_cnt_d   = pend_cnt_q;
    pend_digit_d = pend_digit_q;
    pend_case_d  = pend_case_q;
    if (pend_cnt_q == 2'd2 && hx.valid) begin
      rec          = rec_add(rec, (8'(pend_digit_q) << Nibble) | 8'(hx.value));
      pend_cnt_d   = 2'd0;
      pend_digit_d = 4'd0;
      pend_case_d  = 1'b0;
    end else if (pend_cnt_q == 2'd1 && hx.valid) begin
      pend_cnt_d   = 2'd2;
      pend_digit_d = hx.value;
      pend_case_d  = (in_byte_i >= 8'h61);
    end else begin
      if (pend_cnt_q == 2'd1 || pend_cnt_q == 2'd2) begin
        rec = rec_add(rec, ChPercent);
      end
      if (pend_cnt_q == 2'd2) begin
        rec = rec_add(rec, digit_char(pend_digit_q, pend_case_q));
      end
      pend_cnt_d   = 2'd0;
      pend_digit_d = 4'd0;
      pend_case_d  = 1'b0;
      if (in_byte_i == ChPercent) begin
        pend_cnt_d = 2'd1;
      end else begin
        rec = rec_add(rec, in_byte_i);
      end
    end
    if (in_last_i) begin
      if (pend_cnt_d == 2'd1 || pend_cnt_d == 2'd2) begin
        rec = rec_add(rec, ChPercent);
      end
      if (pend_cnt_d == 2'd2) begin
        rec = rec_add(rec, digit_char(pend_digit_d, pend_case_d));
      end
      pend_cnt_d   = 2'd0;
      pend_digit_d = 4'd0;
      pend_case_d  = 1'b0;
      rec.last     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q   <= 2'd0;
      pend_digit_q <= 4'd0;
      pend_case_q  <= 1'b0;
    end else if (accept) begin
      pend_cnt_q   <= pend_cnt_d;
      pend_digit_q <= pend_digit_d;
      pend_case_q  <= pend_case_d;
    end
  end

  assign q_push_o = accept & (rec.cnt != 2'd0);
  assign q_rec_o  = rec;

  a_cnt_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3) else $error("pending count reached an unused code");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> pend_cnt_q == 2'd0) else $error("last item left state pending");
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |-> q_push_o) else $error("last item produced no record");

endmodule

// File: design/pds_queue.sv
// Short record queue between the front and back ends.
module pds_queue #(
  parameter int unsigned Depth = pds_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pds_pkg::pds_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output pds_pkg::pds_rec_t rec_o,
  output logic              empty_o
);
  import pds_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pds_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("record pushed into a full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");
  a_ptrs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wr_ptr_q == rd_ptr_q) else $error("empty queue with unequal pointers");

endmodule

// File: design/pds_back.sv
// Back end: serializes queued records into single output bytes.
module pds_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pds_pkg::pds_rec_t q_rec_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import pds_pkg::*;

  pds_rec_t   rec_q;
  logic       rec_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load_out, rec_done;
  logic [7:0] sel_byte;

  assign load_out = rec_valid_q & (~out_valid_q | pop_i);
  assign rec_done = load_out & (idx_q == rec_q.cnt - 2'd1);
  assign q_pop_o  = ~q_empty_i & (~rec_valid_q | rec_done);

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = rec_q.data[0];
      2'd1:    sel_byte = rec_q.data[1];
      default: sel_byte = rec_q.data[2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_rec_i;
    end
    if (load_out) begin
      out_byte_q <= sel_byte;
      out_last_q <= rec_q.last & (idx_q == rec_q.cnt - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        rec_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (rec_done) begin
        rec_valid_q <= 1'b0;
      end else if (load_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o    = ~out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

  a_rec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_q |-> rec_q.cnt != 2'd0) else $error("empty record held for output");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_q |-> idx_q < rec_q.cnt) else $error("byte index past record end");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_byte_q))
    else $error("waiting output byte lost");

endmodule

// File: design/percent_decode_stream.sv
// Top level of the streaming percent-escape decoder.
//
//   Channel   Handshake        Payload
//   input     push_i / full_o  in_byte_i, in_last_i
//   result    pop_i / empty_o  out_byte_o, out_last_o
//
// One input item is taken per cycle while the record queue has room.
// Results leave one byte per cycle while pop_i is held; an item that yields two or three bytes
// occupies the output serializer for each of its bytes in turn and may fill the queue.
// A byte passes the record queue, the back-end record register and the output register.
// Reset clears the pending escape state, empties the queue and clears the record and output valid flags.
module percent_decode_stream #(
  parameter int unsigned QueueDepth = pds_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import pds_pkg::*;

  pds_rec_t front_rec, queue_rec;
  logic     front_push, queue_full, queue_empty, back_pop;

  pds_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .q_full_i  (queue_full),
    .q_push_o  (front_push),
    .q_rec_o   (front_rec)
  );

  pds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .rec_i   (front_rec),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .rec_o   (queue_rec),
    .empty_o (queue_empty)
  );

  pds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_rec_i    (queue_rec),
    .q_empty_i  (queue_empty),
    .q_pop_o    (back_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  assign full_o = queue_full;

endmodule

// File: test/tb_percent_decode_stream.sv
// Self-checking testbench for the streaming percent-escape decoder.
`timescale 1ns / 100ps

module tb_percent_decode_stream;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_PCT    = 2'd1,
    ESC_DIGIT  = 2'd2
  } esc_state_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } raw_item_t;

  localparam int NumItems = 210;
  localparam logic [7:0] BorderChars [12] = '{
    8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
    8'h46, 8'h47, 8'h60, 8'h61, 8'h66, 8'h67
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       pop_i = 1'b0;
  logic       full_o;
  logic       empty_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  raw_item_t  raw_q[$];
  dec_byte_t  decoded_q[$];

  esc_state_e esc_state = ESC_NONE;
  logic [3:0] esc_digit = 4'h0;
  logic       esc_lower = 1'b0;

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_strings = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  drain_next = 1'b0;

  percent_decode_stream DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  function automatic nib_t hex_digit(logic [7:0] c);
    nib_t h;
    h = '0;
    if (c >= "0" && c <= "9") begin
      h = {1'b1, 4'(c - 8'h30)};
    end else if (c >= "A" && c <= "F") begin
      h = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= "a" && c <= "f") begin
      h = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return h;
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] v, logic lower);
    if (v < 4'd10) begin
      return 8'h30 + 8'(v);
    end
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic push_byte(logic [7:0] b);
    decoded_q.push_back({b, 1'b0});
  endtask

  task automatic flush_escape();
    if (esc_state == ESC_PCT || esc_state == ESC_DIGIT) begin
      push_byte(pds_pkg::ChPercent);
    end
    if (esc_state == ESC_DIGIT) begin
      push_byte(nibble_char(esc_digit, esc_lower));
    end
    esc_state = ESC_NONE;
    esc_digit = 4'h0;
    esc_lower = 1'b0;
  endtask

  task automatic predict_decode(logic [7:0] b, logic last);
    nib_t h;
    int   first;
    h = hex_digit(b);
    first = decoded_q.size();
    if (esc_state == ESC_DIGIT && h.ok) begin
      push_byte({esc_digit, h.val});
      esc_state = ESC_NONE;
      esc_digit = 4'h0;
      esc_lower = 1'b0;
    end else if (esc_state == ESC_PCT && h.ok) begin
      esc_state = ESC_DIGIT;
      esc_digit = h.val;
      esc_lower = (b >= 8'h61);
    end else begin
      flush_escape();
      if (b == pds_pkg::ChPercent) begin
        esc_state = ESC_PCT;
      end else begin
        push_byte(b);
      end
    end
    if (last) begin
      flush_escape();
      if (decoded_q.size() > first) begin
        decoded_q[decoded_q.size()-1].last = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    n_fail++;
  endtask

  task automatic add_item(logic [7:0] b, logic last);
    raw_item_t it;
    it.data = b;
    it.last = last;
    it.gap = tx_calm ? 0 : $urandom_range(0, 8);
    it.drain = drain_next;
    drain_next = 1'b0;
    raw_q.push_back(it);
    if (last) begin
      n_strings++;
    end
  endtask

  task automatic add_str(string s, bit last);
    for (int i = 0; i < s.len(); i++) begin
      add_item(s[i], last && (i == s.len() - 1));
    end
  endtask

  task automatic add_non_hex();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (hex_digit(b) != '0);
    add_item(b, 1'b0);
  endtask

  task automatic add_hex_char();
    add_item(nibble_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
  endtask

  // Random strings mix valid escapes with random content, plain bytes,
  // hex-range border characters and broken escapes.
  task automatic gen_string();
    int ntok;
    tx_calm = ($urandom_range(0, 2) == 0);
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          add_item(pds_pkg::ChPercent, 1'b0);
          add_hex_char();
          add_hex_char();
        end
        4, 5: add_item(8'($urandom_range(0, 255)), 1'b0);
        6: add_item(BorderChars[$urandom_range(0, 11)], 1'b0);
        7: begin
          add_item(pds_pkg::ChPercent, 1'b0);
          add_non_hex();
        end
        8: begin
          add_item(pds_pkg::ChPercent, 1'b0);
          add_hex_char();
          add_non_hex();
        end
        default: add_item(pds_pkg::ChPercent, 1'b0);
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      add_item(pds_pkg::ChPercent, 1'b0);
      add_hex_char();
    end
    raw_q[raw_q.size()-1].last = 1'b1;
    n_strings++;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      in_byte_i <= 8'h00;
      in_last_i <= 1'b0;
    end else if (!(push_i && full_o)) begin
      if (push_i) begin
        predict_decode(in_byte_i, in_last_i);
        n_sent++;
        void'(raw_q.pop_front());
        if (raw_q.size() != 0) begin
          tx_wait = raw_q[0].gap;
        end
      end
      if (tx_wait > 0) begin
        tx_wait--;
        push_i <= 1'b0;
      end else if (raw_q.size() != 0 && !(raw_q[0].drain && decoded_q.size() != 0)) begin
        push_i <= 1'b1;
        in_byte_i <= raw_q[0].data;
        in_last_i <= raw_q[0].last;
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %02h last %0b", out_byte_o, out_last_o));
        end else begin
          dec_byte_t want;
          want = decoded_q.pop_front();
          if (out_byte_o !== want.data) begin
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte_o, want.data));
          end
          if (out_last_o !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                      out_last_o, want.last, want.data));
          end
        end
        n_checked++;
        if (n_checked % 32 == 0) begin
          rx_calm = ($urandom_range(0, 2) == 0);
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  initial begin
    add_str("%00", 1'b0);
    add_str("%fF", 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_str("%G", 1'b0);
    add_str("%%41", 1'b0);
    add_str("%az", 1'b0);
    add_str("%B%", 1'b1);
    add_str("%c", 1'b1);
    add_str("%", 1'b1);
    add_str("x", 1'b1);
    drain_next = 1'b1;
    while (raw_q.size() < NumItems) begin
      if ($urandom_range(0, 9) == 0) begin
        drain_next = 1'b1;
      end
      gen_string();
    end
    @(posedge rst_ni);
    while (raw_q.size() != 0 || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    $display("Fed %0d input items in %0d strings and checked %0d decoded bytes.",
             n_sent, n_strings, n_checked);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", n_fail);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timeout: %0d input items sent, %0d results checked.", n_sent, n_checked);
    $display("== FAIL ==");
    $finish;
  end

endmodule
